FILE: hw/rtl/spp_pkg.sv
// Shared types, constants and rounding helper for the stereo ping-pong delay.
// Used by every module of the block; depends on nothing.
package spp_pkg;

  localparam int MAX_DELAY  = 32768;
  localparam int ADDR_W     = $clog2(MAX_DELAY);
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 15;
  localparam int FB_W       = 15;
  localparam int ACC_W      = SAMPLE_W + GAIN_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  GAIN_ONE    = GAIN_W'(1 << FRAC_W);
  localparam logic [FB_W-1:0]    FB_CAP      = FB_W'(26214);
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(20000);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WET      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = CFG_IDX_W'(3);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(1 << (SAMPLE_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t in_left;
    sample_t in_right;
  } in_word_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
  } out_word_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } line_pair_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              entry_ok;
  } ptr_t;

  // Round half up at the Q15 point, then clamp to the sample range.
  function automatic sample_t sat_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ROUND_HALF) >>> FRAC_W;
    if (t > SAT_HI) begin
      return SAT_HI[SAMPLE_W-1:0];
    end else if (t < SAT_LO) begin
      return SAT_LO[SAMPLE_W-1:0];
    end
    return t[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/spp_line_ram.sv
// Delay-line storage: both lines side by side in one word, one write and one read port.
// Read data is registered. Depends on spp_pkg.
module spp_line_ram
  import spp_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  line_pair_t        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output line_pair_t        rdata_o
);

  line_pair_t mem_q [MAX_DELAY];
  line_pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read before write on the same address: forwarding upstream covers it
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/spp_fill_track.sv
// Write pointer, read address and fill mark for the delay lines.
// An entry reads as zero until the pointer has passed it once. Depends on spp_pkg.
module spp_fill_track
  import spp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [DELAY_W-1:0] delay_i,
  output ptr_t               ptr_o
);

  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              wrap_q, wrap_d;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_addr = wp_q - ADDR_W'(delay_i);

  always_comb begin
    wp_d   = wp_q;
    wrap_d = wrap_q;
    if (step_i) begin
      wp_d = wp_q + ADDR_W'(1);
      if (&wp_q) begin
        wrap_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      wrap_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      wrap_q <= wrap_d;
    end
  end

  assign ptr_o.rd_addr  = rd_addr;
  assign ptr_o.wr_addr  = wp_q;
  assign ptr_o.entry_ok = wrap_q || (rd_addr < wp_q);

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_q |=> wrap_q)
    else $error("fill mark dropped after wrap");

  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(wp_q))
    else $error("write pointer moved without a frame");

endmodule

FILE: hw/rtl/stereo_ping_pong_delay.sv
// Top level of the stereo ping-pong delay: config registers, three-stage datapath.
// Depends on spp_pkg, spp_line_ram and spp_fill_track.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid_i  in_ready_o  in_data_i         | one stereo input word
//  out     | out_valid_o out_ready_i out_data_o        | one stereo result word
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data  | one register write, always ready
//
// One word per cycle sustained while the output does not stall; the stages are line
// read, feedback and mix multiply, output round and saturate. The feedback multiply-add
// of the line write is combinational; a one-frame delay runs at full rate by forwarding.
// After reset the lines read as zero through a fill mark on the write pointer; no
// clearing pass is needed. A stall on the output freezes the whole pipeline.
module stereo_ping_pong_delay
  import spp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration
  logic               enable_q;
  logic [DELAY_W-1:0] delay_q;
  logic [GAIN_W-1:0]  wet_q;
  logic [FB_W-1:0]    fb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      delay_q  <= DELAY_RESET;
      wet_q    <= '0;
      fb_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:   enable_q <= cfg_data_i[0];
        CFG_DELAY:    delay_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_WET:      wet_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_FEEDBACK: fb_q     <= cfg_data_i[FB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [GAIN_W-1:0]        wet_eff, dry_eff;
  logic [FB_W-1:0]          fb_eff;
  logic signed [GAIN_W:0]   wet_s, dry_s;
  logic signed [FB_W:0]     fb_s;

  assign wet_eff = (wet_q > GAIN_ONE) ? GAIN_ONE : wet_q;
  assign dry_eff = GAIN_ONE - wet_eff;
  assign fb_eff  = (fb_q > FB_CAP) ? FB_CAP : fb_q;
  assign wet_s   = $signed({1'b0, wet_eff});
  assign dry_s   = $signed({1'b0, dry_eff});
  assign fb_s    = $signed({1'b0, fb_eff});

  // pipeline control
  logic adv, accept, rd_en, wr_en;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign rd_en      = accept && enable_q;

  ptr_t ptr;

  spp_fill_track u_fill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (rd_en),
    .delay_i (delay_q),
    .ptr_o   (ptr)
  );

  // stage 1: line data arrives
  logic              v1_q;
  in_word_t          x1_q;
  logic [ADDR_W-1:0] wp1_q;
  logic              ok1_q;
  logic              fwd_hit_q;
  line_pair_t        fwd_data_q;
  line_pair_t        rdata, dsel, wdata;
  sample_t           dl, dr;

  logic signed [ACC_W-1:0] base_l, base_r, acc_wl, acc_wr;
  logic signed [2*SAMPLE_W-1:0] p_fbl, p_fbr;

  assign wr_en = adv && v1_q && enable_q;

  spp_line_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp1_q),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (ptr.rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    dsel = fwd_hit_q ? fwd_data_q : rdata;
    dl   = (ok1_q || fwd_hit_q) ? dsel.left  : '0;
    dr   = (ok1_q || fwd_hit_q) ? dsel.right : '0;
    // cross-coupled: each line takes the other line's delayed sample
    p_fbl  = (2*SAMPLE_W)'(dr) * (2*SAMPLE_W)'(fb_s);
    p_fbr  = (2*SAMPLE_W)'(dl) * (2*SAMPLE_W)'(fb_s);
    base_l = {{(ACC_W-SAMPLE_W-FRAC_W){x1_q.in_left[SAMPLE_W-1]}}, x1_q.in_left,
              {FRAC_W{1'b0}}};
    base_r = {{(ACC_W-SAMPLE_W-FRAC_W){x1_q.in_right[SAMPLE_W-1]}}, x1_q.in_right,
              {FRAC_W{1'b0}}};
    acc_wl = base_l + ACC_W'(p_fbl);
    acc_wr = base_r + ACC_W'(p_fbr);
    wdata.left  = sat_round(acc_wl);
    wdata.right = sat_round(acc_wr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= accept;
      // same-edge write and read of one entry: the RAM returns the old word
      fwd_hit_q <= wr_en && rd_en && (ptr.rd_addr == wp1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q       <= in_data_i;
      wp1_q      <= ptr.wr_addr;
      ok1_q      <= ptr.entry_ok;
      fwd_data_q <= wdata;
    end
  end

  // stage 2: mix products registered
  logic                      v2_q;
  in_word_t                  x2_q;
  logic signed [ACC_W-2:0]   pdl_q, pwl_q, pdr_q, pwr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q  <= x1_q;
      pdl_q <= (ACC_W-1)'(x1_q.in_left) * (ACC_W-1)'(dry_s);
      pwl_q <= (ACC_W-1)'(dl) * (ACC_W-1)'(wet_s);
      pdr_q <= (ACC_W-1)'(x1_q.in_right) * (ACC_W-1)'(dry_s);
      pwr_q <= (ACC_W-1)'(dr) * (ACC_W-1)'(wet_s);
    end
  end

  // output register
  out_word_t out_q, out_d;

  always_comb begin
    if (enable_q) begin
      out_d.out_left  = sat_round(ACC_W'(pdl_q) + ACC_W'(pwl_q));
      out_d.out_right = sat_round(ACC_W'(pdr_q) + ACC_W'(pwr_q));
    end else begin
      out_d.out_left  = x2_q.in_left;
      out_d.out_right = x2_q.in_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fwd_only_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> (v1_q && enable_q && (delay_q == DELAY_W'(1))))
    else $error("forward hit outside a one-frame delay");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv) |=> v1_q)
    else $error("stage 1 word lost during stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while stalled");

endmodule
